@@ rtl/bbc_pkg.sv @@
// bbc_pkg: shared constants, codes and types for the block buffer cache
// used by block_buffer_cache_lru; no dependencies
package bbc_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FINISH = 5'b00100,
    S_READ   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  function automatic logic slot_in_range(logic [4:0] s);
    return 32'(s) < SLOTS;
  endfunction

endpackage

@@ rtl/block_buffer_cache_lru.sv @@
// block_buffer_cache_lru: fully associative buffer cache with reference counts
// and least-recently-released eviction; depends on bbc_pkg
// get: done strobes after the scan, finish and commit states that follow acceptance; the
// scan reads one slot per cycle through the single tag/tick read port
// release, pin, unpin: done strobes after the read and commit states that follow acceptance
// a new request is taken in the cycle done is high; done cannot be stalled
// synchronous reset empties all slots, zeroes counts, clears tick-set flags (ticks then read as zero), clears busy/done
module block_buffer_cache_lru (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  slot_index,
  input  logic [31:0] now_tick,
  output logic        done,
  output logic [4:0]  result_slot,
  output logic        was_hit,
  output logic        needs_fill,
  output logic [1:0]  status
);
  import bbc_pkg::*;

  state_t state;

  // request registers
  action_t     act_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;

  // per-slot control flops
  logic [SLOTS-1:0] tag_valid;
  logic [SLOTS-1:0] data_valid;
  logic [SLOTS-1:0] tick_set;
  logic [7:0]       ref_count [SLOTS];

  // payload memories
  logic [7:0]  tag_device [SLOTS];
  logic [31:0] tag_block  [SLOTS];
  logic [31:0] tick_mem   [SLOTS];

  // registered read port
  idx_t        rd_addr;
  idx_t        rd_idx;
  logic        rd_live;
  logic        rd_tag_valid;
  logic        rd_dvalid;
  logic        rd_tick_set;
  logic [7:0]  rd_count;
  logic [7:0]  rd_dev;
  logic [31:0] rd_blk;
  logic [31:0] rd_tick;
  logic [31:0] rd_tick_eff;

  // scan results
  idx_t        scan_idx;
  logic        found_hit;
  idx_t        hit_idx;
  logic [7:0]  hit_count;
  logic        hit_dvalid;
  logic        found_free;
  idx_t        best_idx;
  logic [31:0] best_tick;

  logic        accept;
  logic        is_match;
  logic        is_better;
  idx_t        slot_idx;
  logic        mem_we;
  logic        tick_we;

  assign accept      = start && (state == S_IDLE);
  assign busy        = (state != S_IDLE);
  assign slot_idx    = IDX_W'(slot_q);
  assign rd_addr     = (state == S_SCAN) ? scan_idx : slot_idx;
  assign rd_tick_eff = rd_tick_set ? rd_tick : 32'd0;
  assign is_match    = rd_live && rd_tag_valid && (rd_dev == dev_q) && (rd_blk == blk_q);
  assign is_better   = rd_live && (rd_count == 8'd0) &&
                       (!found_free || (rd_tick_eff < best_tick));
  assign mem_we      = (state == S_COMMIT) && (act_q == ACT_GET) && !found_hit && found_free;
  assign tick_we     = (state == S_COMMIT) && (act_q == ACT_RELEASE) &&
                       slot_in_range(slot_q) && (rd_count == 8'd1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_device[best_idx] <= dev_q;
      tag_block[best_idx]  <= blk_q;
    end
    if (tick_we) begin
      tick_mem[slot_idx] <= now_q;
    end
    rd_dev  <= tag_device[rd_addr];
    rd_blk  <= tag_block[rd_addr];
    rd_tick <= tick_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_idx       <= rd_addr;
    rd_tag_valid <= tag_valid[rd_addr];
    rd_dvalid    <= data_valid[rd_addr];
    rd_tick_set  <= tick_set[rd_addr];
    rd_count     <= ref_count[rd_addr];
    if (accept) begin
      act_q  <= action_t'(action);
      dev_q  <= device;
      blk_q  <= block_number;
      slot_q <= slot_index;
      now_q  <= now_tick;
    end
    if (is_match && !found_hit) begin
      hit_idx    <= rd_idx;
      hit_count  <= rd_count;
      hit_dvalid <= rd_dvalid;
    end
    if (is_better) begin
      best_idx  <= rd_idx;
      best_tick <= rd_tick_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_live    <= 1'b0;
      scan_idx   <= '0;
      found_hit  <= 1'b0;
      found_free <= 1'b0;
      tag_valid  <= '0;
      data_valid <= '0;
      tick_set   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        ref_count[i] <= 8'd0;
      end
    end else begin
      done    <= 1'b0;
      rd_live <= (state == S_SCAN);
      if (is_match) begin
        found_hit <= 1'b1;
      end
      if (is_better) begin
        found_free <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_idx   <= '0;
            found_hit  <= 1'b0;
            found_free <= 1'b0;
            state      <= (action_t'(action) == ACT_GET) ? S_SCAN : S_READ;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + idx_t'(1);
          if (scan_idx == idx_t'(SLOTS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_COMMIT;
        end
        S_READ: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          was_hit    <= 1'b0;
          needs_fill <= 1'b0;
          status     <= ST_OK;
          result_slot <= slot_q;
          if (act_q == ACT_GET) begin
            priority if (found_hit) begin
              if (hit_count != COUNT_MAX) begin
                ref_count[hit_idx] <= hit_count + 8'd1;
              end
              data_valid[hit_idx] <= 1'b1;
              result_slot <= 5'(hit_idx);
              was_hit     <= 1'b1;
              needs_fill  <= !hit_dvalid;
            end else if (found_free) begin
              tag_valid[best_idx]  <= 1'b1;
              data_valid[best_idx] <= 1'b1;
              ref_count[best_idx]  <= 8'd1;
              result_slot <= 5'(best_idx);
              needs_fill  <= 1'b1;
            end else begin
              result_slot <= 5'd0;
              status      <= ST_NO_FREE;
            end
          end else if (slot_in_range(slot_q)) begin
            if (act_q == ACT_PIN) begin
              if (rd_count != COUNT_MAX) begin
                ref_count[slot_idx] <= rd_count + 8'd1;
              end
            end else if (rd_count == 8'd0) begin
              status <= ST_UNDERFLOW;
            end else begin
              ref_count[slot_idx] <= rd_count - 8'd1;
              if ((act_q == ACT_RELEASE) && (rd_count == 8'd1)) begin
                tick_set[slot_idx] <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> (done && !busy))
    else $error("result strobe missing after commit");

  a_done_only_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_COMMIT))
    else $error("result strobe without commit");

  a_underflow_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_UNDERFLOW)) |-> (!was_hit && !needs_fill))
    else $error("underflow reported with hit or fill");

  a_get_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && (action_t'(action) == ACT_GET)) |=> ((state == S_SCAN) && (scan_idx == '0)))
    else $error("get request did not start scan at slot zero");

endmodule
